### src/mfps_pkg.sv
// Shared constants and types for the minimum falling path sum block.
`timescale 1ns / 1ps

package mfps_pkg;

  // Field widths fixed by the interface.
  localparam int CELL_W = 16;
  localparam int SUM_W  = 32;
  localparam int SIZE_W = 7;

  // Side length after reset, before any configuration transfer.
  localparam int SIZE_RESET = 8;

  // Largest two's complement sum, the start value of the running minimum.
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  // Position flags of one cell, worked out when the cell is taken in.
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
    logic has_left;
    logic has_right;
  } cell_pos_t;

endpackage

### src/mfps_row_store.sv
// Row store: path sums of the latest row, one write and two registered reads.
`timescale 1ns / 1ps

module mfps_row_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic signed [mfps_pkg::SUM_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr_a,
  input  logic [AW-1:0]                    rd_addr_b,
  output logic signed [mfps_pkg::SUM_W-1:0] rd_data_a,
  output logic signed [mfps_pkg::SUM_W-1:0] rd_data_b
);
  import mfps_pkg::*;

  logic signed [SUM_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports; a read in the cycle of a write returns the old entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### src/min_falling_path_sum_top.sv
// A matrix's last cell passes through stage 1 and then loads the result register.
// Throughput: one cell per cycle; the row store reads two entries and writes one each cycle.
// Input stalls only in reset or while a result waits and the next last cell is ready.
// Reset (rst_n low, synchronous) empties the pipeline, sets the side length to 8
// and restarts the matrix; the row store needs no clearing and is not cleared.
`timescale 1ns / 1ps

module min_falling_path_sum_top #(
  parameter int MAX_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: cfg_tdata[6:0] matrix_size, [7] zero.
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,
  // Input: in_tdata[15:0] cell_value.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // Result: out_tdata[31:0] min_path_sum.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);
  import mfps_pkg::*;

  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;
  localparam int N_RESET = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

  // Side length and position of the next cell.
  logic [NW-1:0] n_r, n_nxt;
  logic [AW-1:0] col_r;
  logic [AW-1:0] row_r;

  // Stage 1: the cell being summed.
  logic                    s1_valid_r;
  logic signed [CELL_W-1:0] s1_cell_r;
  logic [AW-1:0]           s1_col_r;
  cell_pos_t               s1_pos_r;
  logic                    s1_fwd_a_r;
  logic                    s1_fwd_b_r;
  logic signed [SUM_W-1:0] s1_fwd_data_r;

  // Running state of the matrix in progress.
  logic signed [SUM_W-1:0] lps_r;
  logic signed [SUM_W-1:0] rmin_r;

  // Result register.
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_data_r;

  logic                    cfg_fire;
  logic                    in_fire;
  logic                    s1_final;
  logic                    s1_adv;
  logic [NW-1:0]           col_ext;
  logic [NW-1:0]           col_inc;
  logic [NW-1:0]           n_last;
  cell_pos_t               pos_w;
  logic                    wr_en;
  logic                    fwd_a_w;
  logic                    fwd_b_w;
  logic signed [SUM_W-1:0] rd_a;
  logic signed [SUM_W-1:0] rd_b;
  logic signed [SUM_W-1:0] old_c;
  logic signed [SUM_W-1:0] right_c;
  logic signed [SUM_W-1:0] best_l;
  logic signed [SUM_W-1:0] best;
  logic signed [SUM_W-1:0] cell_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] min_cand;
  logic [CW-1:0]           cfg_ext;

  // Handshakes.
  assign cfg_tready = rst_n;
  assign cfg_fire   = cfg_tvalid && cfg_tready;
  assign s1_final   = s1_pos_r.last_row && s1_pos_r.last_col;
  assign s1_adv     = s1_valid_r && (!s1_final || !out_valid_r || out_tready);
  assign in_tready  = rst_n && (!s1_valid_r || s1_adv);
  assign in_fire    = in_tvalid && in_tready;

  // Side length from a configuration transfer, kept within 1 .. MAX_SIZE.
  always_comb begin
    cfg_ext = CW'(cfg_tdata[SIZE_W-1:0]);
    n_nxt   = n_r;
    if (cfg_ext == '0) begin
      n_nxt = NW'(1);
    end else if (cfg_ext > CW'(MAX_SIZE)) begin
      n_nxt = NW'(MAX_SIZE);
    end else begin
      n_nxt = NW'(cfg_ext);
    end
  end

  // Position flags of the cell now being taken in.
  assign col_ext = NW'(col_r);
  assign col_inc = col_ext + NW'(1);
  assign n_last  = n_r - NW'(1);

  always_comb begin
    pos_w.first_row = (row_r == '0);
    pos_w.last_row  = (NW'(row_r) == n_last);
    pos_w.last_col  = (col_ext == n_last);
    pos_w.has_left  = (col_r != '0);
    pos_w.has_right = (col_inc < n_r);
  end

  // A write in the cycle of the store read is forwarded into stage 1.
  assign wr_en   = s1_adv;
  assign fwd_a_w = wr_en && (s1_col_r == col_r);
  assign fwd_b_w = wr_en && (s1_col_r == col_inc[AW-1:0]);

  mfps_row_store #(
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_row_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s1_col_r),
    .wr_data   (sum),
    .rd_en     (in_fire),
    .rd_addr_a (col_r),
    .rd_addr_b (col_inc[AW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Path sum of the stage 1 cell: its value plus the best neighbor above.
  always_comb begin
    old_c    = s1_fwd_a_r ? s1_fwd_data_r : rd_a;
    right_c  = s1_fwd_b_r ? s1_fwd_data_r : rd_b;
    best_l   = (s1_pos_r.has_left && (lps_r < old_c)) ? lps_r : old_c;
    best     = (s1_pos_r.has_right && (right_c < best_l)) ? right_c : best_l;
    cell_ext = SUM_W'(s1_cell_r);
    sum      = s1_pos_r.first_row ? cell_ext : (cell_ext + best);
    min_cand = (sum < rmin_r) ? sum : rmin_r;
  end

  // Side length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= NW'(N_RESET);
    end else if (cfg_fire) begin
      n_r <= n_nxt;
    end
  end

  // Column and row counters advance on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_fire) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (pos_w.last_col) begin
        col_r <= '0;
        row_r <= pos_w.last_row ? '0 : (row_r + AW'(1));
      end else begin
        col_r <= col_inc[AW-1:0];
      end
    end
  end

  // Stage 1 valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r     <= in_tdata;
      s1_col_r      <= col_r;
      s1_pos_r      <= pos_w;
      s1_fwd_a_r    <= fwd_a_w;
      s1_fwd_b_r    <= fwd_b_w;
      s1_fwd_data_r <= sum;
    end
  end

  // Left neighbor and running minimum of the final row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lps_r  <= '0;
      rmin_r <= SUM_MAX;
    end else if (cfg_fire) begin
      lps_r  <= '0;
      rmin_r <= SUM_MAX;
    end else if (s1_adv) begin
      if (s1_final) begin
        lps_r  <= '0;
        rmin_r <= SUM_MAX;
      end else begin
        lps_r <= old_c;
        if (s1_pos_r.last_row) begin
          rmin_r <= min_cand;
        end
      end
    end
  end

  // Result register, loaded by the last cell of a matrix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_final) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_final) begin
      out_data_r <= min_cand;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/mfps_checker.sv
// Port-level checks on the minimum falling path sum block, bound to its top level.
`timescale 1ns / 1ps

module mfps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import mfps_pkg::*;

  // A result held back by the sink stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata[SUM_W-1:0]))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A new result rises only after an input transfer, which passes through stage 1 and the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a closing input transfer");

endmodule

bind min_falling_path_sum_top mfps_checker u_mfps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/tb_top.sv
// Self-checking testbench for the minimum falling path sum block.
`timescale 1ns / 1ps

module tb_top;
  import mfps_pkg::*;

  localparam int MAX_SIDE = 64;
  // Cycles to let pass after the last expected result before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CELLS = 960;

  typedef enum bit {ROW_SIZE, ROW_CELL} row_kind_t;
  typedef enum int {VAL_ANY, VAL_NEAR_ZERO, VAL_EXTREME} val_mode_t;

  typedef struct {
    row_kind_t              kind;
    logic [CELL_W-1:0]      val;
    bit                     typed;
    logic signed [SUM_W-1:0] want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_tvalid = 1'b0;
  logic cfg_tready;
  logic [7:0] cfg_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;

  // Model state: path sums of the latest row, position and running minimum.
  logic signed [SUM_W-1:0] col_sum [MAX_SIDE];
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] run_min;
  int unsigned row_pos;
  int unsigned col_pos;
  logic [SIZE_W-1:0] size_reg;

  logic signed [SUM_W-1:0] path_min_q [$];
  int err_cnt = 0;
  int cells_sent = 0;
  int results_seen = 0;
  int size_writes = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  // Directed part: sizes at and below the lower edge, extreme cells, an abandoned matrix.
  dir_row_t dir_tab [27] = '{
    '{ROW_SIZE, 16'd0,    1'b0, 32'sd0},
    '{ROW_CELL, 16'h7FFF, 1'b1, 32'sd32767},
    '{ROW_CELL, 16'h8000, 1'b1, -32'sd32768},
    '{ROW_SIZE, 16'd1,    1'b0, 32'sd0},
    '{ROW_CELL, 16'h0000, 1'b1, 32'sd0},
    '{ROW_SIZE, 16'd2,    1'b0, 32'sd0},
    '{ROW_CELL, 16'd5,    1'b0, 32'sd0},
    '{ROW_CELL, 16'hFFFD, 1'b0, 32'sd0},
    '{ROW_CELL, 16'd7,    1'b0, 32'sd0},
    '{ROW_CELL, 16'd2,    1'b0, 32'sd0},
    '{ROW_SIZE, 16'd3,    1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h8000, 1'b1, -32'sd98304},
    '{ROW_CELL, 16'd100,  1'b0, 32'sd0},
    '{ROW_CELL, 16'd200,  1'b0, 32'sd0},
    '{ROW_SIZE, 16'd2,    1'b0, 32'sd0},
    '{ROW_CELL, 16'h7FFF, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h7FFF, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h7FFF, 1'b0, 32'sd0},
    '{ROW_CELL, 16'h7FFF, 1'b1, 32'sd65534}
  };

  min_falling_path_sum_top #(.MAX_SIZE(MAX_SIDE)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Side length in effect: zero counts as one, anything above the store saturates.
  function automatic int unsigned side_len();
    int unsigned n;
    n = 32'(size_reg);
    if (n == 0) n = 1;
    if (n > MAX_SIDE) n = MAX_SIDE;
    return n;
  endfunction

  function automatic void restart_matrix();
    row_pos = 0;
    col_pos = 0;
    left_sum = '0;
    run_min = SUM_MAX;
  endfunction

  // Folds one cell into the row sums; returns 1 when it completes a matrix.
  function automatic bit fold_cell(input logic signed [CELL_W-1:0] v,
                                   output logic signed [SUM_W-1:0] res);
    int unsigned n;
    int unsigned c;
    logic signed [SUM_W-1:0] above;
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W-1:0] s;
    n = side_len();
    c = col_pos;
    if (c >= n) c = n - 1;
    above = col_sum[c];
    res = '0;
    if (row_pos == 0) begin
      s = SUM_W'(v);
    end else begin
      best = above;
      if (c > 0 && left_sum < best) best = left_sum;
      if (c + 1 < n && col_sum[c + 1] < best) best = col_sum[c + 1];
      s = best + SUM_W'(v);
    end
    left_sum = above;
    col_sum[c] = s;
    if (row_pos + 1 >= n && s < run_min) run_min = s;
    col_pos = c + 1;
    if (col_pos >= n) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= n) begin
        res = run_min;
        restart_matrix();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [CELL_W-1:0] pick_cell(input val_mode_t mode);
    logic [CELL_W-1:0] v;
    case (mode)
      VAL_NEAR_ZERO: begin
        v = CELL_W'($urandom_range(0, 16)) - CELL_W'(8);
      end
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'hFFFF;
          default: v = 16'h0000;
        endcase
      end
      default: begin
        v = CELL_W'($urandom());
      end
    endcase
    return v;
  endfunction

  // Stops the cell stream and waits until every expected result has come.
  task automatic drain_results(input int extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (path_min_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes the side length once the block has gone idle.
  task automatic write_size(input logic [SIZE_W-1:0] v);
    drain_results(SETTLE_CYCLES);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {1'b0, v};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    size_reg = v;
    restart_matrix();
    size_writes++;
  endtask

  // Sends one cell; valid stays high after the transfer for a back-to-back follower.
  task automatic push_cell(input logic [CELL_W-1:0] v, input bit typed,
                           input logic signed [SUM_W-1:0] want);
    int gap;
    logic signed [SUM_W-1:0] res;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    cells_sent++;
    if (fold_cell(v, res)) path_min_q.push_back(typed ? want : res);
  endtask

  task automatic push_matrix_cells(input int count, input val_mode_t mode);
    for (int i = 0; i < count; i++) begin
      push_cell(pick_cell(mode), 1'b0, '0);
    end
  endtask

  // Result side: random stalls, then compare against the oldest expectation.
  initial begin
    int stall;
    logic signed [SUM_W-1:0] want;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      if (path_min_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d",
                 $time, $signed(out_tdata));
        err_cnt++;
      end else begin
        want = path_min_q.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: min_path_sum mismatch, expected %0d, got %0d",
                   $time, want, $signed(out_tdata));
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, then the saturated size.
  initial begin
    int r;
    int n;
    int mats;
    logic [SIZE_W-1:0] raw;
    val_mode_t mode;

    size_reg = SIZE_W'(SIZE_RESET);
    restart_matrix();
    for (int i = 0; i < MAX_SIDE; i++) col_sum[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_SIZE) begin
        write_size(dir_tab[i].val[SIZE_W-1:0]);
      end else begin
        push_cell(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Mostly small matrices, a few medium ones, some abandoned partway.
    while (cells_sent < RANDOM_CELLS) begin
      r = $urandom_range(0, 99);
      if (r < 55) raw = SIZE_W'($urandom_range(1, 4));
      else if (r < 82) raw = SIZE_W'($urandom_range(5, 9));
      else if (r < 88) raw = SIZE_W'($urandom_range(10, 16));
      else raw = '0;
      tx_idle = ($urandom_range(0, 4) != 0);
      rx_idle = ($urandom_range(0, 4) != 0);
      write_size(raw);
      n = side_len();
      mats = (n >= 10) ? 1 : $urandom_range(1, 4);
      for (int m = 0; m < mats; m++) begin
        mode = val_mode_t'($urandom_range(0, 2));
        push_matrix_cells(n * n, mode);
        if ($urandom_range(0, 9) == 0) drain_results(0);
      end
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        push_matrix_cells($urandom_range(1, n * n - 1), VAL_ANY);
      end
    end

    // The first rows of a matrix at the saturated size, sent back to back,
    // then a partial one at a size written as 64 or above.
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    write_size(7'd127);
    for (int i = 0; i < 3 * MAX_SIDE; i++) begin
      push_cell(pick_cell(($urandom_range(0, 1) == 0) ? VAL_ANY : VAL_EXTREME), 1'b0, '0);
    end
    tx_idle = 1'b1;
    write_size(SIZE_W'($urandom_range(64, 126)));
    push_matrix_cells(2 * MAX_SIDE + $urandom_range(1, MAX_SIDE - 1), VAL_ANY);

    drain_results(10);
    $display("Sent %0d cells over %0d size writes (sizes 0 to 127), checked %0d results.",
             cells_sent, size_writes, results_seen);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
